// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean condition at every clock edge outside reset.
`define ORS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define ORS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/ors_pkg.sv =====
// Shared constants and types of the ROM search engine.
package ors_pkg;

  // Field and state widths
  localparam int ROM_BITS  = 64;
  localparam int ROM_W     = 64;
  localparam int IDX_W     = $clog2(ROM_W);
  localparam int POS_W     = 7;
  localparam int COUNT_W   = 8;
  localparam int CMDBYTE_W = 8;
  localparam int BEAT_W    = $clog2(CMDBYTE_W);
  localparam int OPC_W     = 2;
  localparam int STATUS_W  = 2;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0]    REG_SEARCH_CMD   = 2'd0;
  localparam logic [CMDBYTE_W-1:0] SEARCH_CMD_RESET = 8'hF0;

  // Input commands
  localparam logic [OPC_W-1:0] CMD_START = 2'd0;
  localparam logic [OPC_W-1:0] CMD_PASS  = 2'd1;
  localparam logic [OPC_W-1:0] CMD_PAIR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODEV    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // What one accepted word produces: a single result or a command-byte burst
  typedef struct packed {
    logic                 burst;
    logic [CMDBYTE_W-1:0] cmd_byte;
    logic                 write_bit;
    logic                 write_valid;
    logic                 pass_complete;
    logic                 search_done;
    logic [STATUS_W-1:0]  status;
    logic [ROM_W-1:0]     rom_id;
    logic [COUNT_W-1:0]   device_count;
  } desc_t;

  // One result word as it leaves the block
  typedef struct packed {
    logic                write_bit;
    logic                write_valid;
    logic                last_of_run;
    logic                pass_complete;
    logic                search_done;
    logic [STATUS_W-1:0] status;
    logic [ROM_W-1:0]    rom_id;
    logic [COUNT_W-1:0]  device_count;
  } out_word_t;

endpackage

// ===== design/ors_in_if.sv =====
// Input channel of the ROM search engine.
interface ors_in_if;
  logic                       valid;
  logic                       ready;
  logic [ors_pkg::OPC_W-1:0]  command;
  logic                       no_presence;
  logic                       bit_true;
  logic                       bit_complement;

  modport source (output valid, command, no_presence, bit_true, bit_complement,
                  input ready);
  modport sink (input valid, command, no_presence, bit_true, bit_complement,
                output ready);
endinterface

// ===== design/ors_out_if.sv =====
// Result channel of the ROM search engine.
interface ors_out_if;
  logic                          valid;
  logic                          ready;
  logic                          write_bit;
  logic                          write_valid;
  logic                          last_of_run;
  logic                          pass_complete;
  logic                          search_done;
  logic [ors_pkg::STATUS_W-1:0]  status;
  logic [ors_pkg::ROM_W-1:0]     rom_id;
  logic [ors_pkg::COUNT_W-1:0]   device_count;

  modport source (output valid, write_bit, write_valid, last_of_run, pass_complete,
                  search_done, status, rom_id, device_count, input ready);
  modport sink (input valid, write_bit, write_valid, last_of_run, pass_complete,
                search_done, status, rom_id, device_count, output ready);
endinterface

// ===== design/ors_core.sv =====
// Search state and per-word update of the ROM search algorithm.
module ors_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [ors_pkg::OPC_W-1:0]       command,
  input  logic                            no_presence,
  input  logic                            bit_true,
  input  logic                            bit_complement,
  input  logic [ors_pkg::CMDBYTE_W-1:0]   search_cmd,
  output ors_pkg::desc_t                  desc
);

  localparam logic [ors_pkg::POS_W-1:0] POS_FIRST = ors_pkg::POS_W'(1);
  localparam logic [ors_pkg::POS_W-1:0] POS_LAST  = ors_pkg::POS_W'(ors_pkg::ROM_BITS);

  logic [ors_pkg::ROM_W-1:0]   rom_r, rom_nxt;
  logic [ors_pkg::POS_W-1:0]   last_disc_r, last_disc_nxt;
  logic [ors_pkg::POS_W-1:0]   mark_r, mark_nxt;
  logic [ors_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [ors_pkg::COUNT_W-1:0] found_r, found_nxt;
  logic                        in_pass_r, in_pass_nxt;
  logic                        finished_r, finished_nxt;

  logic [ors_pkg::IDX_W-1:0]   idx;
  logic                        bit_old;
  logic                        bit_new;
  logic [ors_pkg::COUNT_W-1:0] found_inc;

  assign idx       = pos_r[ors_pkg::IDX_W-1:0] - ors_pkg::IDX_W'(1);
  assign bit_old   = rom_r[idx];
  assign found_inc = (found_r == ors_pkg::COUNT_MAX) ? found_r
                                                     : found_r + ors_pkg::COUNT_W'(1);

  // Decide the next search state and the result of the current word
  always_comb begin
    rom_nxt       = rom_r;
    last_disc_nxt = last_disc_r;
    mark_nxt      = mark_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    in_pass_nxt   = in_pass_r;
    finished_nxt  = finished_r;
    bit_new       = bit_old;
    desc          = '0;

    if (command == ors_pkg::CMD_START) begin
      rom_nxt       = '0;
      last_disc_nxt = '0;
      mark_nxt      = '0;
      pos_nxt       = POS_FIRST;
      found_nxt     = '0;
      in_pass_nxt   = 1'b0;
      finished_nxt  = 1'b0;
      desc.status   = ors_pkg::ST_OK;
    end else if (command == ors_pkg::CMD_PASS && !in_pass_r && !finished_r) begin
      if (no_presence) begin
        found_nxt        = '0;
        finished_nxt     = 1'b1;
        desc.search_done = 1'b1;
        desc.status      = ors_pkg::ST_NODEV;
      end else begin
        in_pass_nxt   = 1'b1;
        pos_nxt       = POS_FIRST;
        mark_nxt      = '0;
        desc.burst    = 1'b1;
        desc.cmd_byte = search_cmd;
        desc.status   = ors_pkg::ST_OK;
      end
    end else if (command == ors_pkg::CMD_PAIR && in_pass_r) begin
      if (bit_true && bit_complement) begin
        // No device answered: report the partial code and stop
        mark_nxt           = '0;
        last_disc_nxt      = '0;
        in_pass_nxt        = 1'b0;
        finished_nxt       = 1'b1;
        found_nxt          = found_inc;
        desc.pass_complete = 1'b1;
        desc.search_done   = 1'b1;
        desc.status        = ors_pkg::ST_CONFLICT;
        desc.rom_id        = rom_r;
      end else begin
        // Pick the branch to follow and track the newest zero-branch fork
        if (bit_true || bit_complement) begin
          bit_new = bit_true;
        end else if (pos_r == last_disc_r) begin
          bit_new = 1'b1;
        end else if (pos_r > last_disc_r) begin
          bit_new  = 1'b0;
          mark_nxt = pos_r;
        end else begin
          bit_new = bit_old;
          if (!bit_old) begin
            mark_nxt = pos_r;
          end
        end
        rom_nxt[idx]     = bit_new;
        desc.write_bit   = bit_new;
        desc.write_valid = 1'b1;
        desc.status      = ors_pkg::ST_OK;
        if (pos_r >= POS_LAST) begin
          last_disc_nxt      = mark_nxt;
          in_pass_nxt        = 1'b0;
          pos_nxt            = POS_FIRST;
          found_nxt          = found_inc;
          finished_nxt       = finished_r || (mark_nxt == '0);
          desc.pass_complete = 1'b1;
          desc.search_done   = finished_nxt;
          desc.rom_id        = rom_nxt;
        end else begin
          pos_nxt = pos_r + POS_FIRST;
        end
      end
    end else begin
      desc.search_done = finished_r;
      desc.status      = ors_pkg::ST_IGNORED;
    end

    desc.device_count = found_nxt;
  end

  // Hold the search state; advance it on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r       <= '0;
      last_disc_r <= '0;
      mark_r      <= '0;
      pos_r       <= POS_FIRST;
      found_r     <= '0;
      in_pass_r   <= 1'b0;
      finished_r  <= 1'b0;
    end else if (accept) begin
      rom_r       <= rom_nxt;
      last_disc_r <= last_disc_nxt;
      mark_r      <= mark_nxt;
      pos_r       <= pos_nxt;
      found_r     <= found_nxt;
      in_pass_r   <= in_pass_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

// ===== design/ors_emit.sv =====
// Result register that sends one word, or the command byte bit by bit.
module ors_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  ors_pkg::desc_t        desc,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ors_pkg::out_word_t    word
);

  localparam logic [ors_pkg::BEAT_W-1:0] BEAT_LAST =
    ors_pkg::BEAT_W'(ors_pkg::CMDBYTE_W - 1);

  ors_pkg::desc_t              desc_r;
  logic                        valid_r, valid_nxt;
  logic [ors_pkg::BEAT_W-1:0]  beat_r, beat_nxt;
  logic                        last_beat;
  logic                        drain;

  assign last_beat = !desc_r.burst || (beat_r == BEAT_LAST);
  assign drain     = valid_r && out_ready;
  assign can_load  = !valid_r || (out_ready && last_beat);
  assign out_valid = valid_r;

  // Build the outgoing word from the held result
  always_comb begin
    word               = '0;
    word.write_bit     = desc_r.burst ? desc_r.cmd_byte[beat_r] : desc_r.write_bit;
    word.write_valid   = desc_r.burst || desc_r.write_valid;
    word.last_of_run   = last_beat;
    word.pass_complete = desc_r.pass_complete;
    word.search_done   = desc_r.search_done;
    word.status        = desc_r.status;
    word.rom_id        = desc_r.rom_id;
    word.device_count  = desc_r.device_count;
  end

  // Step through the burst and drop the result after its last word
  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (load) begin
      valid_nxt = 1'b1;
      beat_nxt  = '0;
    end else if (drain) begin
      if (last_beat) begin
        valid_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + ors_pkg::BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
  end

endmodule

// ===== design/onewire_rom_search.sv =====
// Top level of the 1-Wire ROM search engine.
//
// Input channel in_ch takes one command word per cycle while in_ch.ready is
// high: start a search, begin a pass with the bus reset presence result, or
// deliver a read bit pair. The search state is updated in the cycle the word
// is accepted and its results are held in an output register toward out_ch.
// A start, a bit pair, an ignored word or a missing presence pulse yields
// one result word, visible on out_ch in the cycle after acceptance.
// A pass with a device present yields eight words carrying the search
// command byte LSB first, the last one marked by last_of_run; these occupy
// the output register one bit per cycle while out_ch.ready is high.
// Throughput is one input word per cycle for single-result words while out_ch
// takes every word; the eight-bit command burst, sent one bit per cycle, sets
// the rate after a pass. in_ch.ready stays high while the output register
// is empty or its final word is taken in the same cycle. When out_ch stalls,
// the held word stays and in_ch.ready drops.
// Reset (rst_n low at a clock edge) clears the search, empties the output
// register and sets the search command to 0xF0. The APB port writes and
// reads that command register at address 0.
module onewire_rom_search (
  input  logic                          clk,
  input  logic                          rst_n,
  ors_in_if.sink                        in_ch,
  ors_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ors_pkg::CFG_AW-1:0]    paddr,
  input  logic [ors_pkg::CFG_DW-1:0]    pwdata,
  output logic [ors_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  logic [ors_pkg::CMDBYTE_W-1:0] search_cmd_r;
  logic                          cfg_wr;
  logic                          accept;
  logic                          can_load;
  ors_pkg::desc_t                desc;
  ors_pkg::out_word_t            word;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ors_pkg::REG_SEARCH_CMD);
  assign prdata = (paddr == ors_pkg::REG_SEARCH_CMD)
                ? ors_pkg::CFG_DW'(search_cmd_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_cmd_r <= ors_pkg::SEARCH_CMD_RESET;
    end else if (cfg_wr) begin
      search_cmd_r <= pwdata[ors_pkg::CMDBYTE_W-1:0];
    end
  end

  // Input handshake
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  ors_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .command        (in_ch.command),
    .no_presence    (in_ch.no_presence),
    .bit_true       (in_ch.bit_true),
    .bit_complement (in_ch.bit_complement),
    .search_cmd     (search_cmd_r),
    .desc           (desc)
  );

  ors_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .desc      (desc),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .word      (word)
  );

  // Result channel payload
  assign out_ch.write_bit     = word.write_bit;
  assign out_ch.write_valid   = word.write_valid;
  assign out_ch.last_of_run   = word.last_of_run;
  assign out_ch.pass_complete = word.pass_complete;
  assign out_ch.search_done   = word.search_done;
  assign out_ch.status        = word.status;
  assign out_ch.rom_id        = word.rom_id;
  assign out_ch.device_count  = word.device_count;

endmodule

// ===== design/ors_checker.sv =====
// Port-level checks of the ROM search engine, bound to the top level.
`include "assert_macros.svh"

module ors_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          write_bit,
  input logic                          write_valid,
  input logic                          last_of_run,
  input logic                          pass_complete,
  input logic                          search_done,
  input logic [ors_pkg::STATUS_W-1:0]  status,
  input logic [ors_pkg::COUNT_W-1:0]   device_count
);

  // A stalled word stays offered
  `ORS_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // A completed pass is the final word of its run and is either good or a conflict
  `ORS_ASSERT(a_pass_complete_shape, !(out_valid && pass_complete) || (last_of_run && (status == ors_pkg::ST_OK || status == ors_pkg::ST_CONFLICT)), "pass_complete on a wrong word")

  // A missing presence pulse ends the search with no devices counted
  `ORS_ASSERT(a_nodev_clears, !(out_valid && status == ors_pkg::ST_NODEV) || (search_done && device_count == '0 && last_of_run), "no-device word carries a count or no done flag")

  // Nothing to write means the write bit is low
  `ORS_ASSERT(a_idle_write_bit, !(out_valid && !write_valid) || !write_bit, "write_bit set without write_valid")

endmodule

bind onewire_rom_search ors_checker u_ors_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .write_bit     (out_ch.write_bit),
  .write_valid   (out_ch.write_valid),
  .last_of_run   (out_ch.last_of_run),
  .pass_complete (out_ch.pass_complete),
  .search_done   (out_ch.search_done),
  .status        (out_ch.status),
  .device_count  (out_ch.device_count)
);

// ===== dv/onewire_rom_search_tb.sv =====
// Self-checking testbench for the 1-Wire ROM search engine with emulated bus devices.
module onewire_rom_search_tb;
  import ors_pkg::*;

  // Command value that the engine has no use for
  localparam logic [OPC_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WORD_BUDGET = 260;

  // Tracks the search state and the result words each accepted word must produce
  class search_tracker;
    logic [CMDBYTE_W-1:0] search_cmd;
    logic [ROM_W-1:0]     rom_bits;
    logic [POS_W-1:0]     last_disc;
    logic [POS_W-1:0]     disc_mark;
    logic [POS_W-1:0]     bit_pos;
    logic [COUNT_W-1:0]   found;
    logic                 in_pass;
    logic                 finished;
    logic                 last_dir;
    out_word_t            awaited_words[$];
    int                   errors;
    int                   words_seen;
    int                   results_checked;
    int                   codes_done;
    int                   conflicts;
    int                   peak_count;

    function new();
      search_cmd = SEARCH_CMD_RESET;
      clear_search();
      last_dir = 1'b0;
      errors = 0;
      words_seen = 0;
      results_checked = 0;
      codes_done = 0;
      conflicts = 0;
      peak_count = 0;
    endfunction

    function void clear_search();
      rom_bits  = '0;
      last_disc = '0;
      disc_mark = '0;
      bit_pos   = 7'd1;
      found     = '0;
      in_pass   = 1'b0;
      finished  = 1'b0;
    endfunction

    function void count_device();
      if (found != COUNT_MAX) found++;
      if (int'(found) > peak_count) peak_count = int'(found);
    endfunction

    function void queue_word(logic wbit, logic wvalid, logic last, logic pass_done,
                             logic done, logic [STATUS_W-1:0] st, logic [ROM_W-1:0] rom);
      out_word_t w;
      w.write_bit     = wbit;
      w.write_valid   = wvalid;
      w.last_of_run   = last;
      w.pass_complete = pass_done;
      w.search_done   = done;
      w.status        = st;
      w.rom_id        = rom;
      w.device_count  = found;
      if (pass_done) codes_done++;
      awaited_words.push_back(w);
    endfunction

    // Advance the search by one accepted word and queue its result words
    function void predict_results(logic [OPC_W-1:0] cmd, logic no_pres, logic bt, logic bc);
      logic [POS_W-1:0] pos;
      logic [IDX_W-1:0] idx;
      logic             wbit;
      words_seen++;
      pos = bit_pos;
      idx = IDX_W'(pos - 7'd1);
      if (cmd == CMD_START) begin
        clear_search();
        queue_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK, '0);
      end else if (cmd == CMD_PASS && !in_pass && !finished) begin
        if (no_pres) begin
          found = '0;
          finished = 1'b1;
          queue_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, ST_NODEV, '0);
        end else begin
          in_pass = 1'b1;
          bit_pos = 7'd1;
          disc_mark = '0;
          for (int n = 0; n < CMDBYTE_W; n++)
            queue_word(search_cmd[n], 1'b1, n == CMDBYTE_W - 1, 1'b0, 1'b0, ST_OK, '0);
        end
      end else if (cmd == CMD_PAIR && in_pass) begin
        if (bt && bc) begin
          // both lines high: nobody answered, close the pass with what we have
          disc_mark = '0;
          last_disc = '0;
          in_pass = 1'b0;
          finished = 1'b1;
          conflicts++;
          count_device();
          queue_word(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, ST_CONFLICT, rom_bits);
        end else begin
          if (bt || bc)
            rom_bits[idx] = bt;
          else if (pos == last_disc)
            rom_bits[idx] = 1'b1;
          else if (pos > last_disc) begin
            rom_bits[idx] = 1'b0;
            disc_mark = pos;
          end else if (!rom_bits[idx])
            disc_mark = pos;
          wbit = rom_bits[idx];
          last_dir = wbit;
          if (pos >= ROM_BITS) begin
            last_disc = disc_mark;
            in_pass = 1'b0;
            bit_pos = 7'd1;
            count_device();
            if (last_disc == '0) finished = 1'b1;
            queue_word(wbit, 1'b1, 1'b1, 1'b1, finished, ST_OK, rom_bits);
          end else begin
            bit_pos = pos + 7'd1;
            queue_word(wbit, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK, '0);
          end
        end
      end else begin
        queue_word(1'b0, 1'b0, 1'b1, 1'b0, finished, ST_IGNORED, '0);
      end
    endfunction

    function void cmp_field(string name, logic [ROM_W-1:0] want, logic [ROM_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    // Compare one delivered result word with the oldest awaited one
    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited_words.size() == 0) begin
        $error("result word arrived with nothing awaited");
        errors++;
        return;
      end
      want = awaited_words.pop_front();
      results_checked++;
      cmp_field("write_bit", want.write_bit, got.write_bit);
      cmp_field("write_valid", want.write_valid, got.write_valid);
      cmp_field("last_of_run", want.last_of_run, got.last_of_run);
      cmp_field("pass_complete", want.pass_complete, got.pass_complete);
      cmp_field("search_done", want.search_done, got.search_done);
      cmp_field("status", want.status, got.status);
      cmp_field("rom_id", want.rom_id, got.rom_id);
      cmp_field("device_count", want.device_count, got.device_count);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                idle_level;
  search_tracker     sb;

  ors_in_if  in_bus();
  ors_out_if out_bus();

  onewire_rom_search dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hang guard
  initial begin
    #20000000;
    $display("onewire_rom_search_tb: FAIL");
    $finish;
  end

  // Idle length: level 0 never idles, level 1 barely, level 2 mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_level == 0) return 0;
    if (idle_level == 1) return (r < 10) ? 1 : 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result channel in random stretches
  initial begin
    int run;
    int gap;
    out_bus.ready = 1'b0;
    forever begin
      run = $urandom_range(1, 16);
      @(negedge clk);
      out_bus.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Check every result word taken from the block
  always @(posedge clk) begin : watch_results
    out_word_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.write_bit     = out_bus.write_bit;
      got.write_valid   = out_bus.write_valid;
      got.last_of_run   = out_bus.last_of_run;
      got.pass_complete = out_bus.pass_complete;
      got.search_done   = out_bus.search_done;
      got.status        = out_bus.status;
      got.rom_id        = out_bus.rom_id;
      got.device_count  = out_bus.device_count;
      sb.check_result(got);
    end
  end

  // Offer one input word, hold it until taken, then idle a while
  task automatic send_word(logic [OPC_W-1:0] cmd, logic no_pres, logic bt, logic bc);
    int gap;
    @(negedge clk);
    in_bus.valid          <= 1'b1;
    in_bus.command        <= cmd;
    in_bus.no_presence    <= no_pres;
    in_bus.bit_true       <= bt;
    in_bus.bit_complement <= bc;
    do @(posedge clk); while (!in_bus.ready);
    sb.predict_results(cmd, no_pres, bt, bc);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid          <= 1'b0;
      in_bus.command        <= OPC_W'($urandom);
      in_bus.no_presence    <= 1'($urandom);
      in_bus.bit_true       <= 1'($urandom);
      in_bus.bit_complement <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every awaited result word has come out
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the search command register, then read it back
  task automatic program_search_cmd(logic [CMDBYTE_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SEARCH_CMD;
    pwdata  <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.search_cmd = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CMDBYTE_W-1:0] !== sb.search_cmd) begin
      $error("search_cmd readback: expected %0h, got %0h", sb.search_cmd,
             prdata[CMDBYTE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Full search over a bus of emulated devices whose codes differ in a few bits.
  // mischief 1 forces a read conflict, 2 restarts mid-pass, 3 slips in a stray pass.
  task automatic run_search(int ndev, int mischief);
    logic [ROM_W-1:0] devs[8];
    logic [ROM_W-1:0] base;
    logic [7:0]       live;
    logic             bt;
    logic             bc;
    logic             aborted;
    int               passes;
    int               stop_at;
    base = {$urandom, $urandom};
    for (int d = 0; d < ndev; d++)
      devs[d] = base ^ ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    stop_at = (mischief != 0) ? $urandom_range(0, ROM_BITS - 1) : ROM_BITS;
    aborted = 1'b0;
    passes = 0;
    send_word(CMD_START, 1'($urandom), 1'($urandom), 1'($urandom));
    while (!aborted && !sb.finished && passes < ndev + 2) begin
      live = 8'((1 << ndev) - 1);
      send_word(CMD_PASS, 1'b0, 1'($urandom), 1'($urandom));
      for (int i = 0; i < ROM_BITS && !aborted && sb.in_pass; i++) begin
        if (passes == 0 && i == stop_at) begin
          case (mischief)
            1: begin
              send_word(CMD_PAIR, 1'($urandom), 1'b1, 1'b1);
              aborted = 1'b1;
            end
            2: begin
              send_word(CMD_START, 1'($urandom), 1'($urandom), 1'($urandom));
              aborted = 1'b1;
            end
            default: send_word(CMD_PASS, 1'($urandom), 1'($urandom), 1'($urandom));
          endcase
        end
        if (!aborted) begin
          // wired-AND of every device still in the running
          bt = 1'b1;
          bc = 1'b1;
          for (int d = 0; d < ndev; d++) begin
            if (live[d]) begin
              bt &= devs[d][i];
              bc &= ~devs[d][i];
            end
          end
          send_word(CMD_PAIR, 1'($urandom), bt, bc);
          for (int d = 0; d < ndev; d++)
            if (devs[d][i] != sb.last_dir) live[d] = 1'b0;
        end
      end
      passes++;
    end
    // at random, poke the engine once more after the search loop ends
    if ($urandom_range(0, 1) == 1)
      send_word(OPC_W'($urandom_range(1, 2)), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    int pick;
    sb = new();
    idle_level            = 2;
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.command        = CMD_START;
    in_bus.no_presence    = 1'b0;
    in_bus.bit_true       = 1'b0;
    in_bus.bit_complement = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed: stray words, missing presence, command burst, conflict, restart
    send_word(CMD_PAIR, 1'b0, 1'b1, 1'b0);
    send_word(CMD_UNUSED, 1'b1, 1'b1, 1'b1);
    send_word(CMD_PASS, 1'b1, 1'b0, 1'b0);
    send_word(CMD_PASS, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PAIR, 1'b0, 1'b0, 1'b1);
    send_word(CMD_START, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PASS, 1'b0, 1'b1, 1'b1);
    send_word(CMD_PASS, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PAIR, 1'b1, 1'b1, 1'b0);
    send_word(CMD_PAIR, 1'b0, 1'b0, 1'b1);
    send_word(CMD_PAIR, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PAIR, 1'b0, 1'b1, 1'b1);
    send_word(CMD_PAIR, 1'b0, 1'b0, 1'b0);
    send_word(CMD_START, 1'b1, 1'b1, 1'b1);
    send_word(CMD_PASS, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PAIR, 1'b0, 1'b0, 1'b0);
    send_word(CMD_START, 1'b0, 1'b0, 1'b0);
    send_word(CMD_PASS, 1'b1, 1'b0, 1'b0);
    send_word(CMD_UNUSED, 1'b0, 1'b0, 1'b0);

    settle();
    program_search_cmd(8'h00);

    // Random: mostly full searches over emulated devices, some noise and pauses
    while (sb.words_seen < WORD_BUDGET) begin
      pick = $urandom_range(0, 99);
      idle_level = ($urandom_range(0, 3) == 0) ? 0 : 2;
      if (pick < 20) begin
        settle();
        case ($urandom_range(0, 3))
          0: program_search_cmd(SEARCH_CMD_RESET);
          1: program_search_cmd(8'hEC);
          2: program_search_cmd(8'hFF);
          default: program_search_cmd(CMDBYTE_W'($urandom));
        endcase
      end
      if (pick < 65)
        run_search($urandom_range(1, 2),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      else if (pick < 90)
        repeat ($urandom_range(2, 10))
          send_word(OPC_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      else
        settle();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d input words and %0d result words: %0d ROM codes, %0d conflicts,",
             sb.words_seen, sb.results_checked, sb.codes_done, sb.conflicts);
    $display("peak device count %0d, search command reprogrammed between searches",
             sb.peak_count);
    if (sb.errors == 0 && sb.awaited_words.size() == 0)
      $display("onewire_rom_search_tb: PASS");
    else
      $display("onewire_rom_search_tb: FAIL");
    $finish;
  end

endmodule
